// ===== design/mope_pkg.sv =====
// constants, class height table and arctangent table for the position estimator
`default_nettype none

package mope_pkg;

   localparam int NUM_CLASSES  = 80;
   localparam int CORDIC_STEPS = 16;
   localparam int DIV_BITS     = 23;
   localparam int FRONT_STAGES = (DIV_BITS > CORDIC_STEPS) ? DIV_BITS : CORDIC_STEPS;
   localparam int LATENCY      = FRONT_STAGES + CORDIC_STEPS + 6;

   localparam int VEC_W = 29;
   localparam int ROT_W = 34;
   localparam int ZR_W  = 33;

   localparam logic [29:0]        INV_GAIN_Q30 = 30'd652032874;
   localparam logic signed [28:0] POS_LIMIT    = 29'sd8388607;

   localparam logic [7:0]  REG_FOCAL         = 8'd0;
   localparam logic [7:0]  REG_IMAGE_WIDTH   = 8'd1;
   localparam logic [15:0] FOCAL_RESET       = 16'd4434;
   localparam logic [12:0] IMAGE_WIDTH_RESET = 13'd320;

   function automatic logic [10:0] class_height(input logic [7:0] cls);
      logic [10:0] h;
      if ({1'b0, cls} >= 9'(NUM_CLASSES)) begin
         h = 11'd0;
      end else begin
         unique case (cls)
            8'd0:    h = 11'd1700;
            8'd56:   h = 11'd850;
            8'd57:   h = 11'd900;
            8'd59:   h = 11'd600;
            8'd60:   h = 11'd750;
            8'd61:   h = 11'd800;
            8'd62:   h = 11'd650;
            8'd63:   h = 11'd350;
            8'd71:   h = 11'd900;
            8'd72:   h = 11'd1800;
            default: h = 11'd0;
         endcase
      end
      return h;
   endfunction

   function automatic logic [31:0] atan_val(input logic [4:0] idx);
      logic [31:0] a;
      unique case (idx)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ===== design/monocular_object_position_estimator.sv =====
// top level: pipelined range divider, bearing and position cordics
`default_nettype none

// Position estimator for one detected box per item.
// Input: start with the req_ fields; an item is taken at every edge with
// start high and busy low. busy is high only while reset is held, so an
// item can enter in every cycle.
// Output: rsp_strobe marks each result for exactly one cycle, in order.
// Pipeline: after the input register, a 23 stage restoring divider runs side by
// side with the 16 step bearing cordic, then come the rotation cordic, a split
// multiply by the inverse gain, a rounding sum and a saturating output stage.
// Throughput is one item per cycle.
// Configuration: csr_valid/csr_ready with csr_index and csr_data; ready is
// always high; index 0 is the focal length, index 1 the image width, others
// are dropped. Write only while no item is in flight.
// Reset (synchronous) empties the pipeline and restores both registers.
// The receiver cannot stall; nothing here holds a result back.
module monocular_object_position_estimator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [7:0]         req_object_class,
   input  wire logic [11:0]        req_box_left,
   input  wire logic [11:0]        req_box_width,
   input  wire logic [11:0]        req_box_height,
   input  wire logic [15:0]        req_camera_heading,
   output logic                    rsp_strobe,
   output logic                    rsp_estimate_valid,
   output logic [10:0]             rsp_object_height_mm,
   output logic [22:0]             rsp_range_mm,
   output logic signed [23:0]      rsp_pos_x_mm,
   output logic [9:0]              rsp_pos_y_mm,
   output logic signed [23:0]      rsp_pos_z_mm,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_index,
   input  wire logic [15:0]        csr_data
);
   import mope_pkg::*;

   // configuration
   logic [15:0] focal_ff;
   logic [12:0] img_w_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= FOCAL_RESET;
         img_w_ff <= IMAGE_WIDTH_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_FOCAL) begin
            focal_ff <= csr_data;
         end
         if (csr_index == REG_IMAGE_WIDTH) begin
            img_w_ff <= csr_data[12:0];
         end
      end
   end

   // input stage
   logic               s0_v_ff, s0_v_in;
   logic               s0_ok_ff, s0_ok_in;
   logic [10:0]        s0_hmm_ff, s0_hmm_in;
   logic [11:0]        s0_bh_ff;
   logic signed [14:0] s0_d_ff, s0_d_in;
   logic [15:0]        s0_head_ff;

   assign s0_v_in   = start && !busy;
   assign s0_hmm_in = class_height(req_object_class);
   assign s0_ok_in  = (s0_hmm_in != 11'd0) && (req_box_height != 12'd0);
   assign s0_d_in   = $signed({2'b00, req_box_left, 1'b0})
                    + $signed({3'b000, req_box_width})
                    - $signed({2'b00, img_w_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= s0_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ok_ff   <= s0_ok_in;
      s0_hmm_ff  <= s0_hmm_in;
      s0_bh_ff   <= req_box_height;
      s0_d_ff    <= s0_d_in;
      s0_head_ff <= req_camera_heading;
   end

   // divider and bearing cordic, side by side
   logic                      f_v_ff    [0:FRONT_STAGES];
   logic                      f_ok_ff   [0:FRONT_STAGES];
   logic [10:0]               f_hmm_ff  [0:FRONT_STAGES];
   logic [15:0]               f_head_ff [0:FRONT_STAGES];
   logic [11:0]               f_bh_ff   [0:FRONT_STAGES];
   logic [11:0]               f_rem_ff  [0:FRONT_STAGES];
   logic [DIV_BITS-1:0]       f_n_ff    [0:FRONT_STAGES];
   logic [DIV_BITS-1:0]       f_q_ff    [0:FRONT_STAGES];
   logic signed [VEC_W-1:0]   f_x_ff    [0:FRONT_STAGES];
   logic signed [VEC_W-1:0]   f_y_ff    [0:FRONT_STAGES];
   logic [31:0]               f_z_ff    [0:FRONT_STAGES];

   logic [26:0] f0_prod_in;

   assign f0_prod_in = 27'(s0_hmm_ff) * 27'(focal_ff);

   always_ff @(posedge clock) begin
      f_ok_ff[0]   <= s0_ok_ff;
      f_hmm_ff[0]  <= s0_hmm_ff;
      f_head_ff[0] <= s0_head_ff;
      f_bh_ff[0]   <= s0_bh_ff;
      f_rem_ff[0]  <= 12'd0;
      f_n_ff[0]    <= f0_prod_in[26:4];
      f_q_ff[0]    <= '0;
      f_x_ff[0]    <= $signed(VEC_W'({focal_ff, 8'b0}));
      f_y_ff[0]    <= $signed({{(VEC_W-26){s0_d_ff[14]}}, s0_d_ff, 11'b0});
      f_z_ff[0]    <= 32'd0;
   end

   for (genvar k = 0; k < FRONT_STAGES; k++) begin : g_front
      logic [11:0]             rem_in;
      logic [DIV_BITS-1:0]     n_in;
      logic [DIV_BITS-1:0]     q_in;
      logic signed [VEC_W-1:0] x_in;
      logic signed [VEC_W-1:0] y_in;
      logic [31:0]             z_in;

      if (k < DIV_BITS) begin : g_div
         logic [12:0] rem_sh;
         logic        ge;
         assign rem_sh = {f_rem_ff[k], f_n_ff[k][DIV_BITS-1]};
         assign ge     = rem_sh >= {1'b0, f_bh_ff[k]};
         assign rem_in = ge ? 12'(rem_sh - {1'b0, f_bh_ff[k]}) : rem_sh[11:0];
         assign n_in   = {f_n_ff[k][DIV_BITS-2:0], 1'b0};
         assign q_in   = {f_q_ff[k][DIV_BITS-2:0], ge};
      end else begin : g_div_pass
         assign rem_in = f_rem_ff[k];
         assign n_in   = f_n_ff[k];
         assign q_in   = f_q_ff[k];
      end

      if (k < CORDIC_STEPS) begin : g_vec
         logic signed [VEC_W-1:0] xs;
         logic signed [VEC_W-1:0] ys;
         assign xs = f_x_ff[k] >>> k;
         assign ys = f_y_ff[k] >>> k;
         always_comb begin
            if (!f_y_ff[k][VEC_W-1]) begin
               x_in = f_x_ff[k] + ys;
               y_in = f_y_ff[k] - xs;
               z_in = f_z_ff[k] + atan_val(5'(k));
            end else begin
               x_in = f_x_ff[k] - ys;
               y_in = f_y_ff[k] + xs;
               z_in = f_z_ff[k] - atan_val(5'(k));
            end
         end
      end else begin : g_vec_pass
         assign x_in = f_x_ff[k];
         assign y_in = f_y_ff[k];
         assign z_in = f_z_ff[k];
      end

      always_ff @(posedge clock) begin
         f_ok_ff[k+1]   <= f_ok_ff[k];
         f_hmm_ff[k+1]  <= f_hmm_ff[k];
         f_head_ff[k+1] <= f_head_ff[k];
         f_bh_ff[k+1]   <= f_bh_ff[k];
         f_rem_ff[k+1]  <= rem_in;
         f_n_ff[k+1]    <= n_in;
         f_q_ff[k+1]    <= q_in;
         f_x_ff[k+1]    <= x_in;
         f_y_ff[k+1]    <= y_in;
         f_z_ff[k+1]    <= z_in;
      end
   end

   // fold the world bearing into the right half plane
   logic [31:0] ang_in;
   logic        fold_in;

   assign ang_in  = {f_head_ff[FRONT_STAGES], 16'b0} + f_z_ff[FRONT_STAGES];
   assign fold_in = ang_in[31] ^ ang_in[30];

   // rotation cordic
   logic                    r_v_ff    [0:CORDIC_STEPS];
   logic                    r_ok_ff   [0:CORDIC_STEPS];
   logic                    r_flip_ff [0:CORDIC_STEPS];
   logic [10:0]             r_hmm_ff  [0:CORDIC_STEPS];
   logic [22:0]             r_rng_ff  [0:CORDIC_STEPS];
   logic signed [ROT_W-1:0] r_x_ff    [0:CORDIC_STEPS];
   logic signed [ROT_W-1:0] r_y_ff    [0:CORDIC_STEPS];
   logic signed [ZR_W-1:0]  r_z_ff    [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      r_ok_ff[0]   <= f_ok_ff[FRONT_STAGES];
      r_flip_ff[0] <= fold_in;
      r_hmm_ff[0]  <= f_hmm_ff[FRONT_STAGES];
      r_rng_ff[0]  <= f_q_ff[FRONT_STAGES];
      r_x_ff[0]    <= $signed({3'b000, f_q_ff[FRONT_STAGES], 8'b0});
      r_y_ff[0]    <= '0;
      r_z_ff[0]    <= $signed({ang_in[31] ^ fold_in, ang_in[31] ^ fold_in, ang_in[30:0]});
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      logic signed [ROT_W-1:0] xs;
      logic signed [ROT_W-1:0] ys;
      logic signed [ZR_W-1:0]  at;
      logic signed [ROT_W-1:0] x_in;
      logic signed [ROT_W-1:0] y_in;
      logic signed [ZR_W-1:0]  z_in;

      assign xs = r_x_ff[k] >>> k;
      assign ys = r_y_ff[k] >>> k;
      assign at = $signed({1'b0, atan_val(5'(k))});

      always_comb begin
         if (!r_z_ff[k][ZR_W-1]) begin
            x_in = r_x_ff[k] - ys;
            y_in = r_y_ff[k] + xs;
            z_in = r_z_ff[k] - at;
         end else begin
            x_in = r_x_ff[k] + ys;
            y_in = r_y_ff[k] - xs;
            z_in = r_z_ff[k] + at;
         end
      end

      always_ff @(posedge clock) begin
         r_ok_ff[k+1]   <= r_ok_ff[k];
         r_flip_ff[k+1] <= r_flip_ff[k];
         r_hmm_ff[k+1]  <= r_hmm_ff[k];
         r_rng_ff[k+1]  <= r_rng_ff[k];
         r_x_ff[k+1]    <= x_in;
         r_y_ff[k+1]    <= y_in;
         r_z_ff[k+1]    <= z_in;
      end
   end

   // inverse gain, split into high and low partial products
   logic                m1_v_ff;
   logic                m1_ok_ff;
   logic                m1_flip_ff;
   logic [10:0]         m1_hmm_ff;
   logic [22:0]         m1_rng_ff;
   logic signed [48:0]  m1_xhi_ff, m1_yhi_ff;
   logic [45:0]         m1_xlo_ff, m1_ylo_ff;
   logic signed [30:0]  gain_s;

   assign gain_s = $signed({1'b0, INV_GAIN_Q30});

   always_ff @(posedge clock) begin
      m1_ok_ff   <= r_ok_ff[CORDIC_STEPS];
      m1_flip_ff <= r_flip_ff[CORDIC_STEPS];
      m1_hmm_ff  <= r_hmm_ff[CORDIC_STEPS];
      m1_rng_ff  <= r_rng_ff[CORDIC_STEPS];
      m1_xhi_ff  <= 49'($signed(r_x_ff[CORDIC_STEPS][ROT_W-1:16])) * 49'(gain_s);
      m1_yhi_ff  <= 49'($signed(r_y_ff[CORDIC_STEPS][ROT_W-1:16])) * 49'(gain_s);
      m1_xlo_ff  <= 46'(r_x_ff[CORDIC_STEPS][15:0]) * 46'(INV_GAIN_Q30);
      m1_ylo_ff  <= 46'(r_y_ff[CORDIC_STEPS][15:0]) * 46'(INV_GAIN_Q30);
   end

   // sum and round half up
   logic               m2_v_ff;
   logic               m2_ok_ff;
   logic               m2_flip_ff;
   logic [10:0]        m2_hmm_ff;
   logic [22:0]        m2_rng_ff;
   logic signed [27:0] m2_x_ff, m2_y_ff;
   logic signed [65:0] sum_x_in, sum_y_in;

   assign sum_x_in = (66'(m1_xhi_ff) <<< 16) + $signed({20'b0, m1_xlo_ff})
                   + 66'sh20_0000_0000;
   assign sum_y_in = (66'(m1_yhi_ff) <<< 16) + $signed({20'b0, m1_ylo_ff})
                   + 66'sh20_0000_0000;

   always_ff @(posedge clock) begin
      m2_ok_ff   <= m1_ok_ff;
      m2_flip_ff <= m1_flip_ff;
      m2_hmm_ff  <= m1_hmm_ff;
      m2_rng_ff  <= m1_rng_ff;
      m2_x_ff    <= sum_x_in[65:38];
      m2_y_ff    <= sum_y_in[65:38];
   end

   // sign, saturate and drop invalid boxes
   logic signed [28:0] px_s, pz_s;
   logic signed [23:0] px_in, pz_in;

   assign px_s = m2_flip_ff ? -29'(m2_y_ff) : 29'(m2_y_ff);
   assign pz_s = m2_flip_ff ? -29'(m2_x_ff) : 29'(m2_x_ff);

   always_comb begin
      if (px_s > POS_LIMIT) begin
         px_in = POS_LIMIT[23:0];
      end else if (px_s < -POS_LIMIT) begin
         px_in = 24'(-POS_LIMIT);
      end else begin
         px_in = px_s[23:0];
      end
      if (pz_s > POS_LIMIT) begin
         pz_in = POS_LIMIT[23:0];
      end else if (pz_s < -POS_LIMIT) begin
         pz_in = 24'(-POS_LIMIT);
      end else begin
         pz_in = pz_s[23:0];
      end
   end

   logic               out_strobe_ff;
   logic               out_valid_ff;
   logic [10:0]        out_hmm_ff;
   logic [22:0]        out_rng_ff;
   logic signed [23:0] out_x_ff;
   logic [9:0]         out_y_ff;
   logic signed [23:0] out_z_ff;

   always_ff @(posedge clock) begin
      out_valid_ff <= m2_ok_ff;
      out_hmm_ff   <= m2_hmm_ff;
      out_rng_ff   <= m2_ok_ff ? m2_rng_ff : 23'd0;
      out_x_ff     <= m2_ok_ff ? px_in : 24'sd0;
      out_y_ff     <= m2_ok_ff ? m2_hmm_ff[10:1] : 10'd0;
      out_z_ff     <= m2_ok_ff ? pz_in : 24'sd0;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= FRONT_STAGES; i++) begin
            f_v_ff[i] <= 1'b0;
         end
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            r_v_ff[i] <= 1'b0;
         end
         m1_v_ff       <= 1'b0;
         m2_v_ff       <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         f_v_ff[0] <= s0_v_ff;
         for (int i = 1; i <= FRONT_STAGES; i++) begin
            f_v_ff[i] <= f_v_ff[i-1];
         end
         r_v_ff[0] <= f_v_ff[FRONT_STAGES];
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            r_v_ff[i] <= r_v_ff[i-1];
         end
         m1_v_ff       <= r_v_ff[CORDIC_STEPS];
         m2_v_ff       <= m1_v_ff;
         out_strobe_ff <= m2_v_ff;
      end
   end

   assign rsp_strobe           = out_strobe_ff;
   assign rsp_estimate_valid   = out_valid_ff;
   assign rsp_object_height_mm = out_hmm_ff;
   assign rsp_range_mm         = out_rng_ff;
   assign rsp_pos_x_mm         = out_x_ff;
   assign rsp_pos_y_mm         = out_y_ff;
   assign rsp_pos_z_mm         = out_z_ff;

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(start && !busy, LATENCY))
      else $error("result strobe out of step with accepted items");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_estimate_valid) |->
         (rsp_range_mm == 23'd0 && rsp_pos_x_mm == 24'sd0 &&
          rsp_pos_y_mm == 10'd0 && rsp_pos_z_mm == 24'sd0))
      else $error("invalid estimate carries nonzero position");

   a_half_height : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_estimate_valid) |->
         (rsp_pos_y_mm == rsp_object_height_mm[10:1] && rsp_object_height_mm != 11'd0))
      else $error("vertical centre does not match class height");

   a_saturate : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_pos_x_mm != 24'sh800000 && rsp_pos_z_mm != 24'sh800000))
      else $error("position escaped saturation");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_monocular_object_position_estimator.sv =====
// self-checking testbench for the monocular object position estimator
`default_nettype none

module tb_monocular_object_position_estimator;
   timeunit 1ns;
   timeprecision 1ps;
   import mope_pkg::*;

   typedef struct {
      logic [7:0]  cls;
      logic [11:0] left;
      logic [11:0] width;
      logic [11:0] height;
      logic [15:0] heading;
   } box_type;

   typedef struct {
      logic               valid;
      logic [10:0]        height_mm;
      logic [22:0]        range_mm;
      logic signed [23:0] x_mm;
      logic [9:0]         y_mm;
      logic signed [23:0] z_mm;
   } estimate_type;

   localparam logic [31:0] ARCTAN [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
   localparam logic [7:0] KNOWN [10] = '{8'd0, 8'd56, 8'd57, 8'd59, 8'd60, 8'd61, 8'd62,
                                          8'd63, 8'd71, 8'd72};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [7:0]  req_object_class = '0;
   logic [11:0] req_box_left = '0;
   logic [11:0] req_box_width = '0;
   logic [11:0] req_box_height = '0;
   logic [15:0] req_camera_heading = '0;
   logic rsp_strobe, rsp_estimate_valid;
   logic [10:0] rsp_object_height_mm;
   logic [22:0] rsp_range_mm;
   logic signed [23:0] rsp_pos_x_mm, rsp_pos_z_mm;
   logic [9:0] rsp_pos_y_mm;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   box_type      pending_boxes[$];
   estimate_type expected_estimates[$];
   logic [15:0] focal_copy;
   logic [12:0] width_copy;
   int gap_left = 0;
   int errors = 0;

   monocular_object_position_estimator DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [10:0] class_mm_lookup(logic [7:0] cls);
      case (cls)
         8'd0: return 11'd1700;
         8'd56: return 11'd850;
         8'd57, 8'd71: return 11'd900;
         8'd59: return 11'd600;
         8'd60: return 11'd750;
         8'd61: return 11'd800;
         8'd62: return 11'd650;
         8'd63: return 11'd350;
         8'd72: return 11'd1800;
         default: return 11'd0;
      endcase
   endfunction

   function automatic logic signed [23:0] scale_axis(longint v, bit flip);
      longint r;
      r = (v * 64'sd652032874 + (64'sd1 <<< 37)) >>> 38;
      if (flip) r = -r;
      if (r > 8388607) r = 8388607;
      if (r < -8388607) r = -8388607;
      return r[23:0];
   endfunction

   function automatic estimate_type locate_box(box_type b, logic [15:0] f, logic [12:0] w);
      estimate_type e;
      longint hmm, rng, vx, vy, nx, za;
      logic [31:0] z, ang;
      bit flip;
      e = '{default: '0};
      hmm = class_mm_lookup(b.cls);
      e.height_mm = hmm[10:0];
      if (hmm == 0 || b.height == 0) return e;
      rng = (hmm * longint'(f)) / (16 * longint'(b.height));
      if (rng > 8388607) rng = 8388607;
      vx = longint'(f) * 256;
      vy = (2 * longint'(b.left) + longint'(b.width) - longint'(w)) * 2048;
      z = '0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         if (vy >= 0) begin
            nx = vx + (vy >>> i); vy = vy - (vx >>> i); z = z + ARCTAN[i];
         end else begin
            nx = vx - (vy >>> i); vy = vy + (vx >>> i); z = z - ARCTAN[i];
         end
         vx = nx;
      end
      ang = {b.heading, 16'h0000} + z;
      flip = 1'b0;
      if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
         ang = ang + 32'h80000000;
         flip = 1'b1;
      end
      za = longint'($signed(ang));
      vx = rng * 256;
      vy = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         if (za >= 0) begin
            nx = vx - (vy >>> i); vy = vy + (vx >>> i); za = za - longint'(ARCTAN[i]);
         end else begin
            nx = vx + (vy >>> i); vy = vy - (vx >>> i); za = za + longint'(ARCTAN[i]);
         end
         vx = nx;
      end
      e.valid = 1'b1;
      e.range_mm = rng[22:0];
      e.x_mm = scale_axis(vy, flip);
      e.y_mm = hmm[10:1];
      e.z_mm = scale_axis(vx, flip);
      return e;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // csr copy
   always @(posedge clock) begin
      if (reset) begin
         focal_copy <= FOCAL_RESET;
         width_copy <= IMAGE_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FOCAL: focal_copy <= csr_data;
            REG_IMAGE_WIDTH: width_copy <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // driver
   always @(posedge clock) begin
      box_type b;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            b = '{req_object_class, req_box_left, req_box_width, req_box_height,
                  req_camera_heading};
            expected_estimates.push_back(locate_box(b, focal_copy, width_copy));
         end
         if (start && busy) begin
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_boxes.size() > 0) begin
            b = pending_boxes.pop_front();
            req_object_class <= b.cls;
            req_box_left <= b.left;
            req_box_width <= b.width;
            req_box_height <= b.height;
            req_camera_heading <= b.heading;
            start <= 1'b1;
            gap_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      estimate_type e;
      if (!reset && rsp_strobe) begin
         if (expected_estimates.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            e = expected_estimates.pop_front();
            if (rsp_estimate_valid !== e.valid)
               report_mismatch("estimate_valid", rsp_estimate_valid, e.valid);
            if (rsp_object_height_mm !== e.height_mm)
               report_mismatch("object_height_mm", rsp_object_height_mm, e.height_mm);
            if (rsp_range_mm !== e.range_mm)
               report_mismatch("range_mm", rsp_range_mm, e.range_mm);
            if (rsp_pos_x_mm !== e.x_mm)
               report_mismatch("pos_x_mm", rsp_pos_x_mm, e.x_mm);
            if (rsp_pos_y_mm !== e.y_mm)
               report_mismatch("pos_y_mm", rsp_pos_y_mm, e.y_mm);
            if (rsp_pos_z_mm !== e.z_mm)
               report_mismatch("pos_z_mm", rsp_pos_z_mm, e.z_mm);
         end
      end
   end

   task automatic write_reg(logic [7:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_boxes.size() > 0 || start || expected_estimates.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic add_box(logic [7:0] c, logic [11:0] l, logic [11:0] w, logic [11:0] h,
                          logic [15:0] hd);
      pending_boxes.push_back('{c, l, w, h, hd});
   endtask

   function automatic box_type random_box();
      box_type b;
      int p;
      p = $urandom_range(99);
      b.cls = (p < 70) ? KNOWN[$urandom_range(9)] : 8'($urandom_range(255));
      b.height = ($urandom_range(19) == 0) ? 12'd0 :
                 ($urandom_range(3) == 0) ? 12'($urandom_range(4095, 1)) :
                                            12'($urandom_range(300, 1));
      if ($urandom_range(1)) begin
         b.left = 12'($urandom_range(600));
         b.width = 12'($urandom_range(300));
      end else begin
         b.left = 12'($urandom_range(4095));
         b.width = 12'($urandom_range(4095));
      end
      b.heading = 16'($urandom_range(65535));
      return b;
   endfunction

   initial begin
      logic [15:0] f_set [7];
      logic [15:0] w_set [7];
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < 10; k++) add_box(KNOWN[k], 12'd100, 12'd40, 12'(20 + 10 * k),
                                           16'(k * 6553));
      add_box(8'd1, 12'd100, 12'd40, 12'd50, 16'd0);
      add_box(8'd79, 12'd100, 12'd40, 12'd50, 16'd0);
      add_box(8'd80, 12'd100, 12'd40, 12'd50, 16'd0);
      add_box(8'd255, 12'd4095, 12'd4095, 12'd4095, 16'd65535);
      add_box(8'd0, 12'd160, 12'd0, 12'd0, 16'd0);
      add_box(8'd72, 12'd0, 12'd0, 12'd1, 16'd16384);
      add_box(8'd72, 12'd4095, 12'd4095, 12'd1, 16'd32768);
      add_box(8'd0, 12'd160, 12'd0, 12'd4095, 16'd49152);
      add_box(8'd63, 12'd0, 12'd4095, 12'd2, 16'd16383);
      add_box(8'd0, 12'd150, 12'd20, 12'd10, 16'd32767);
      drain();
      f_set = '{16'd65535, 16'd1, 16'd0, 16'd4434, 16'd0, 16'd0, 16'd0};
      w_set = '{16'd1, 16'd4096, 16'd8191, 16'd0, 16'd0, 16'd0, 16'd0};
      for (int k = 4; k < 7; k++) begin
         f_set[k] = 16'($urandom_range(8000, 200));
         w_set[k] = 16'($urandom_range(4096, 1));
      end
      for (int ph = 0; ph < 7; ph++) begin
         write_reg(REG_FOCAL, f_set[ph]);
         write_reg(REG_IMAGE_WIDTH, w_set[ph]);
         write_reg(8'd2 + 8'(ph), 16'($urandom_range(65535)));
         for (int n = 0; n < 247; n++) pending_boxes.push_back(random_box());
         drain();
      end
      if (errors == 0) begin
         $display("monocular_object_position_estimator verification clean");
      end else begin
         $display("monocular_object_position_estimator verification failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("monocular_object_position_estimator verification failed");
      $finish;
   end

endmodule

`default_nettype wire
